FILE: src/sam_pkg.sv
// shared types and constants for the suffix automaton builder
`timescale 1ns / 1ps
package sam_pkg;
    localparam int NODE_CAPACITY = 8192;
    localparam int ALPHABET_SIZE = 26;
    localparam int NODE_W = $clog2(NODE_CAPACITY);
    localparam int CNT_W = $clog2(NODE_CAPACITY + 1);
    localparam int SYM_W = 5;
    localparam int TRANS_DEPTH = NODE_CAPACITY * ALPHABET_SIZE;
    localparam int TADDR_W = $clog2(TRANS_DEPTH);
    localparam int GUARD_W = CNT_W;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_RD_P,
        ST_WT_P,
        ST_CHK_P,
        ST_RD_Q,
        ST_WT_Q,
        ST_DEC,
        ST_W1_RD,
        ST_W1_WT,
        ST_W1_CHK,
        ST_W1_Q,
        ST_W1_QWT,
        ST_W1_DEC,
        ST_NEWNODE,
        ST_W2_RD,
        ST_W2_WT,
        ST_W2_CHK,
        ST_W2_Q,
        ST_W2_QWT,
        ST_W2_DEC,
        ST_CL_INIT,
        ST_CL_CP_RD,
        ST_CL_CP_WR,
        ST_CL_RD,
        ST_CL_WT,
        ST_CL_CHK,
        ST_RES_RD,
        ST_RES_WT,
        ST_OUT
    } sam_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load_in;       // capture input beat and apply restart
        logic clr_step;      // clear one transition memory entry
        logic rd_cell_w;     // read trans[w][sym] and length/link of w
        logic rd_node_q;     // read length of q (taken from cell data)
        logic capture_q;     // q <= cell data
        logic w_follow;      // w <= link[w]
        logic w_from_p;      // w <= p
        logic alloc_np;      // create new node np
        logic wr_cell_np;    // trans[w][sym] <= np
        logic set_np_link_q; // link[np] <= q
        logic cl_init;       // allocate clone, length len[w]+1, link copied from q
        logic cl_rd;         // read trans[q][k]
        logic cl_wr;         // write trans[nq][k]
        logic cl_redirect;   // trans[w][sym] <= nq
        logic set_np_link_nq;
        logic last_q;        // last <= q
        logic last_nq;
        logic last_np;
        logic rd_res;        // read length/link of last
        logic set_ovf;
        logic clr_ovf;
    } sam_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic sym_ok;
        logic cell_zero;     // cell data is zero
        logic cell_is_q;     // cell data equals q
        logic len_match;     // len[q] == len[w] + 1
        logic fit1;
        logic fit2;
        logic guard_done;
        logic cp_last;       // last copy index
    } sam_sts_t;
endpackage

FILE: src/sam_datapath.sv
// datapath with transition, length and link memories for the suffix automaton
`timescale 1ns / 1ps
module sam_datapath
    import sam_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [SYM_W-1:0]  in_symbol,
    input  logic              in_new_string,
    input  sam_cmd_t          cmd,
    output sam_sts_t          sts,
    output logic [NODE_W-1:0] res_node,
    output logic [NODE_W-1:0] res_length,
    output logic [NODE_W-1:0] res_link,
    output logic [CNT_W-1:0]  res_count,
    output logic              res_ovf
);
    logic [NODE_W-1:0] trans_mem [TRANS_DEPTH];
    logic [NODE_W-1:0] len_mem [NODE_CAPACITY];
    logic [NODE_W-1:0] link_mem [NODE_CAPACITY];

    logic [SYM_W-1:0]  sym_reg;
    logic [NODE_W-1:0] last_reg, p_reg, w_reg, q_reg, np_reg, nq_reg;
    logic [NODE_W-1:0] lenw_reg, linkw_reg, lenq_reg, lenp_reg;
    logic [NODE_W-1:0] linkq_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [GUARD_W-1:0] guard_reg;
    logic [SYM_W-1:0]  k_reg;
    logic              ovf_reg;

    // transition memory single port: address mux
    logic [TADDR_W-1:0] t_addr;
    logic [NODE_W-1:0]  t_wdata;
    logic               t_we;
    logic [NODE_W-1:0]  t_rnode;
    logic [SYM_W-1:0]   t_rsym;
    logic [NODE_W-1:0]  ones_node;
    logic [TADDR_W-1:0] clr_addr_reg;
    logic [NODE_W-1:0]  t_rdata;
    logic               sent_reg;
    logic [NODE_W-1:0]  cell_rd;

    // length / link memories
    logic [NODE_W-1:0] n_raddr, n_waddr, len_wdata, link_wdata;
    logic len_we, link_we;
    logic [NODE_W-1:0] len_rd, link_rd;
    logic [NODE_W-1:0] n_raddr_next;
    logic n_sent_reg, n_root_reg;
    logic [NODE_W-1:0] len_eff, link_eff;
    logic [NODE_W-1:0] p_next_src;
    logic q_rd_pend_reg;
    logic [NODE_W:0] lenw_plus;

    assign ones_node = NODE_W'(1);

    always_comb
    begin
        t_rnode = w_reg;
        t_rsym  = sym_reg;
        t_we    = 1'b0;
        t_wdata = cell_rd;
        if (cmd.clr_step)
        begin
            t_we    = 1'b1;
            t_wdata = '0;
        end
        else if (cmd.cl_rd)
        begin
            t_rnode = q_reg;
            t_rsym  = k_reg;
        end
        else if (cmd.cl_wr)
        begin
            t_rnode = nq_reg;
            t_rsym  = k_reg;
            t_we    = 1'b1;
        end
        else if (cmd.wr_cell_np)
        begin
            t_we    = 1'b1;
            t_wdata = np_reg;
        end
        else if (cmd.cl_redirect)
        begin
            t_we    = 1'b1;
            t_wdata = nq_reg;
        end
    end

    // clear sweep walks the whole memory linearly
    assign t_addr = cmd.clr_step ? clr_addr_reg
                  : TADDR_W'(TADDR_W'(t_rnode) * TADDR_W'(ALPHABET_SIZE) + TADDR_W'(t_rsym));

    always_ff @(posedge clk)
    begin
        if (t_we)
            trans_mem[t_addr] <= t_wdata;
        t_rdata <= trans_mem[t_addr];
    end

    // sentinel row reads as all root
    assign cell_rd = sent_reg ? ones_node : t_rdata;

    always_comb
    begin
        n_raddr_next = w_reg;
        if (cmd.rd_node_q)
            n_raddr_next = cell_rd;
        else if (cmd.rd_res)
            n_raddr_next = last_reg;
        len_we = 1'b0; link_we = 1'b0;
        n_waddr = np_reg; len_wdata = '0; link_wdata = '0;
        if (cmd.alloc_np)
        begin
            len_we = 1'b1; link_we = 1'b1;
            n_waddr = NODE_W'(count_reg); len_wdata = NODE_W'(lenp_reg + 1'b1);
        end
        else if (cmd.set_np_link_q)
        begin
            link_we = 1'b1; n_waddr = np_reg; link_wdata = q_reg;
        end
        else if (cmd.set_np_link_nq)
        begin
            link_we = 1'b1; n_waddr = np_reg; link_wdata = nq_reg;
        end
        else if (cmd.cl_init)
        begin
            len_we = 1'b1; link_we = 1'b1;
            n_waddr = NODE_W'(count_reg); len_wdata = NODE_W'(lenw_reg + 1'b1);
            link_wdata = linkq_reg; // link of q captured after the read of q
        end
        else if (cmd.cl_rd && k_reg == '0)
        begin
            link_we = 1'b1; n_waddr = q_reg; link_wdata = nq_reg;
        end
    end
    assign n_raddr = n_raddr_next;

    always_ff @(posedge clk)
    begin
        if (len_we)
            len_mem[n_waddr] <= len_wdata;
        if (link_we)
            link_mem[n_waddr] <= link_wdata;
        len_rd  <= len_mem[n_raddr];
        link_rd <= link_mem[n_raddr];
    end

    // sentinel length is minus one, root length and link are zero; neither is ever written
    assign len_eff  = n_sent_reg ? '1 : (n_root_reg ? '0 : len_rd);
    assign link_eff = (n_sent_reg || n_root_reg) ? '0 : link_rd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg <= NODE_W'(1);
            count_reg <= CNT_W'(2);
            clr_addr_reg <= '0;
            ovf_reg <= 1'b0;
            sent_reg <= 1'b0;
            n_sent_reg <= 1'b0;
            n_root_reg <= 1'b0;
        end
        else
        begin
            sent_reg <= (t_rnode == '0) && !cmd.clr_step && !t_we;
            n_sent_reg <= (n_raddr == '0);
            n_root_reg <= (n_raddr == NODE_W'(1));
            if (cmd.clr_step)
                clr_addr_reg <= clr_addr_reg + 1'b1;
            if (cmd.load_in && in_new_string)
                last_reg <= NODE_W'(1);
            if (cmd.alloc_np || cmd.cl_init)
                count_reg <= count_reg + 1'b1;
            if (cmd.last_q)  last_reg <= q_reg;
            if (cmd.last_nq) last_reg <= nq_reg;
            if (cmd.last_np) last_reg <= np_reg;
            if (cmd.set_ovf) ovf_reg <= 1'b1;
            if (cmd.clr_ovf) ovf_reg <= 1'b0;
        end
    end

    assign p_next_src = (cmd.load_in && in_new_string) ? NODE_W'(1) : last_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            sym_reg <= in_symbol;
            p_reg   <= p_next_src;
            w_reg   <= p_next_src;
            guard_reg <= '0;
        end
        if (cmd.rd_cell_w)
        begin
            lenw_reg  <= len_eff;
            linkw_reg <= link_eff;
        end
        if (cmd.w_from_p)
        begin
            w_reg <= p_reg;
            guard_reg <= '0;
        end
        if (cmd.w_follow)
        begin
            w_reg <= linkw_reg;
            guard_reg <= guard_reg + 1'b1;
        end
        if (cmd.capture_q)
            q_reg <= cell_rd;
        if (cmd.alloc_np)
            np_reg <= NODE_W'(count_reg);
        if (cmd.cl_init)
        begin
            nq_reg <= NODE_W'(count_reg);
            k_reg <= '0;
        end
        if (cmd.cl_wr)
            k_reg <= k_reg + 1'b1;
    end

    // capture length of q and link of q after read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q_rd_pend_reg <= 1'b0;
        else
            q_rd_pend_reg <= cmd.rd_node_q;
    end
    always_ff @(posedge clk)
    begin
        if (q_rd_pend_reg)
        begin
            lenq_reg <= len_eff;
            linkq_reg <= link_eff;
        end
        if (cmd.load_in)
            lenp_reg <= '0;
        if (cmd.rd_cell_w && w_reg == p_reg && guard_reg == '0)
            lenp_reg <= len_eff;
    end

    assign lenw_plus = {1'b0, lenw_reg} + 1'b1;

    assign sts.clr_done   = (clr_addr_reg == TADDR_W'(TRANS_DEPTH - 1));
    assign sts.sym_ok     = (sym_reg < SYM_W'(ALPHABET_SIZE));
    assign sts.cell_zero  = (cell_rd == '0);
    assign sts.cell_is_q  = (cell_rd == q_reg);
    assign sts.len_match  = (lenq_reg == NODE_W'(lenw_plus));
    assign sts.fit1       = ({1'b0, count_reg} + 1'b1) <= (CNT_W+1)'(NODE_CAPACITY);
    assign sts.fit2       = ({1'b0, count_reg} + 2'd2) <= (CNT_W+1)'(NODE_CAPACITY);
    assign sts.guard_done = (guard_reg >= GUARD_W'(NODE_CAPACITY));
    assign sts.cp_last    = (k_reg == SYM_W'(ALPHABET_SIZE - 1));

    assign res_node   = last_reg;
    assign res_length = len_eff;
    assign res_link   = link_eff;
    assign res_count  = count_reg;
    assign res_ovf    = ovf_reg;
endmodule

FILE: src/sam_controller.sv
// sequencing state machine for the suffix automaton builder
`timescale 1ns / 1ps
module sam_controller
    import sam_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  sam_sts_t sts,
    output sam_cmd_t cmd
);
    sam_state_t state_reg, state_next;
    logic direct_reg, direct_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            direct_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            direct_reg <= direct_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        direct_next = direct_reg;
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_done)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    cmd.clr_ovf = 1'b1;
                    state_next = ST_RD_P;
                end
            end
            ST_RD_P:
            begin
                cmd.rd_cell_w = 1'b0;
                state_next = sts.sym_ok ? ST_WT_P : ST_RES_RD;
            end
            ST_WT_P:
            begin
                cmd.rd_cell_w = 1'b1;
                state_next = ST_CHK_P;
            end
            ST_CHK_P:
            begin
                if (sts.cell_zero)
                begin
                    direct_next = 1'b0;
                    state_next = ST_W1_CHK;
                end
                else
                begin
                    direct_next = 1'b1;
                    cmd.capture_q = 1'b1;
                    cmd.rd_node_q = 1'b1;
                    state_next = ST_RD_Q;
                end
            end
            ST_RD_Q: state_next = ST_DEC;
            ST_DEC:
            begin
                if (sts.len_match)
                begin
                    cmd.last_q = 1'b1;
                    state_next = ST_RES_RD;
                end
                else if (!sts.fit1)
                begin
                    cmd.set_ovf = 1'b1;
                    state_next = ST_RES_RD;
                end
                else
                    state_next = ST_CL_INIT;
            end
            ST_W1_RD:
            begin
                state_next = ST_W1_WT;
            end
            ST_W1_WT:
            begin
                cmd.rd_cell_w = 1'b1;
                state_next = ST_W1_CHK;
            end
            ST_W1_CHK:
            begin
                if (sts.cell_zero && !sts.guard_done)
                begin
                    cmd.w_follow = 1'b1;
                    state_next = ST_W1_RD;
                end
                else
                begin
                    cmd.capture_q = 1'b1;
                    cmd.rd_node_q = 1'b1;
                    state_next = ST_W1_Q;
                end
            end
            ST_W1_Q: state_next = ST_W1_DEC;
            ST_W1_DEC:
            begin
                if (!(sts.len_match ? sts.fit1 : sts.fit2))
                begin
                    cmd.set_ovf = 1'b1;
                    state_next = ST_RES_RD;
                end
                else
                    state_next = ST_NEWNODE;
            end
            ST_NEWNODE:
            begin
                cmd.alloc_np = 1'b1;
                cmd.w_from_p = 1'b1;
                state_next = ST_W2_RD;
            end
            ST_W2_RD: state_next = ST_W2_WT;
            ST_W2_WT:
            begin
                cmd.rd_cell_w = 1'b1;
                state_next = ST_W2_CHK;
            end
            ST_W2_CHK:
            begin
                if (sts.cell_zero && !sts.guard_done)
                begin
                    cmd.wr_cell_np = 1'b1;
                    cmd.w_follow = 1'b1;
                    state_next = ST_W2_RD;
                end
                else
                begin
                    cmd.capture_q = 1'b1;
                    cmd.rd_node_q = 1'b1;
                    state_next = ST_W2_Q;
                end
            end
            ST_W2_Q: state_next = ST_W2_DEC;
            ST_W2_DEC:
            begin
                if (sts.len_match)
                begin
                    cmd.set_np_link_q = 1'b1;
                    cmd.last_np = 1'b1;
                    state_next = ST_RES_RD;
                end
                else
                    state_next = ST_CL_INIT;
            end
            ST_CL_INIT:
            begin
                cmd.cl_init = 1'b1;
                state_next = ST_CL_CP_RD;
            end
            ST_CL_CP_RD:
            begin
                cmd.cl_rd = 1'b1;
                state_next = ST_CL_CP_WR;
            end
            ST_CL_CP_WR:
            begin
                cmd.cl_wr = 1'b1;
                state_next = sts.cp_last ? ST_CL_RD : ST_CL_CP_RD;
            end
            ST_CL_RD: state_next = ST_CL_WT;
            ST_CL_WT:
            begin
                cmd.rd_cell_w = 1'b1;
                state_next = ST_CL_CHK;
            end
            ST_CL_CHK:
            begin
                if (!sts.cell_zero && sts.cell_is_q && !sts.guard_done)
                begin
                    cmd.cl_redirect = 1'b1;
                    cmd.w_follow = 1'b1;
                    state_next = ST_CL_RD;
                end
                else
                begin
                    if (direct_reg)
                        cmd.last_nq = 1'b1;
                    else
                    begin
                        cmd.set_np_link_nq = 1'b1;
                        cmd.last_np = 1'b1;
                    end
                    state_next = ST_RES_RD;
                end
            end
            ST_RES_RD:
            begin
                cmd.rd_res = 1'b1;
                state_next = ST_RES_WT;
            end
            ST_RES_WT:
            begin
                cmd.rd_res = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // keep reading the last node so the result stays steady while stalled
                cmd.rd_res = 1'b1;
                out_valid = 1'b1;
                if (out_ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule

FILE: src/suffix_automaton_builder_unit.sv
// top level of the generalized suffix automaton builder
`timescale 1ns / 1ps
// a symbol of 26 or more leaves the automaton unchanged; a matching existing transition is
// followed; otherwise a new node is made by walking suffix links, and a clone copies the
// transitions of q and redirects transitions to itself; a full store raises overflow instead
// one beat in flight; the next beat is taken in the cycle after the result beat is accepted
// reset: async active low; a clearing pass over every transition entry precedes s_axis_tready
module suffix_automaton_builder_unit
    import sam_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // symbol[4:0], new_string[5], zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata   // last_node, last_length, last_link, node_count, overflow
);
    sam_cmd_t cmd;
    sam_sts_t sts;
    logic [NODE_W-1:0] res_node, res_length, res_link;
    logic [CNT_W-1:0]  res_count;
    logic              res_ovf;

    sam_controller u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .sts(sts), .cmd(cmd)
    );

    sam_datapath u_dp (
        .clk(clk), .rst_n(rst_n),
        .in_symbol(s_axis_tdata[4:0]), .in_new_string(s_axis_tdata[5]),
        .cmd(cmd), .sts(sts),
        .res_node(res_node), .res_length(res_length), .res_link(res_link),
        .res_count(res_count), .res_ovf(res_ovf)
    );

    // output beat packed from lowest bit up
    assign m_axis_tdata = {2'b00, res_ovf, res_count, res_link, res_length, res_node};
endmodule
